[rtl/core/sensor_to_led_color_fill_assert.svh]
// assertion macros for the sensor to led color fill block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SENSOR_TO_LED_COLOR_FILL_ASSERT_SVH
`define SENSOR_TO_LED_COLOR_FILL_ASSERT_SVH

// same-cycle implication, off during reset
`define STLCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define STLCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/stlcf_pkg.sv]
// shared types and constants of the sensor to led color fill block
// no dependencies
package stlcf_pkg;

  localparam int unsigned ColorW   = 24;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned SensorW  = 16;
  localparam int unsigned BoundW   = 7;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned FlagsW   = 3;
  localparam int unsigned CfgIdxW  = 4;

  // widths of the blend datapath; diff, delta and product are signed
  localparam int unsigned DiffW    = SensorW + 1;
  localparam int unsigned DeltaW   = ChanW + 1;
  localparam int unsigned ProdW    = DiffW + DeltaW;
  localparam int unsigned MagW     = 24;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DivSteps = MagW;

  localparam logic [1:0] ChanLast  = 2'd2;

  // rule flag bits
  localparam int unsigned FlagEnable      = 0;
  localparam int unsigned FlagFadePressed = 1;
  localparam int unsigned FlagFadeRelease = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ON_COLOR       = 4'd0,
    CFG_ON_FADE_COLOR  = 4'd1,
    CFG_OFF_COLOR      = 4'd2,
    CFG_OFF_FADE_COLOR = 4'd3,
    CFG_THRESHOLD      = 4'd4,
    CFG_RULE_FLAGS     = 4'd5,
    CFG_LED_BEGIN      = 4'd6,
    CFG_LED_END        = 4'd7
  } cfg_reg_e;

  // pick one 8-bit channel out of a packed color, red first
  function automatic logic [ChanW-1:0] chan_of(input logic [ColorW-1:0] col,
                                               input logic [1:0] ch);
    logic [ChanW-1:0] res;
    case (ch)
      2'd0:    res = col[23:16];
      2'd1:    res = col[15:8];
      default: res = col[7:0];
    endcase
    return res;
  endfunction

endpackage

[rtl/core/sensor_to_led_color_fill.sv]
// top level of the sensor to led color fill block
// depends on stlcf_pkg and sensor_to_led_color_fill_assert.svh
//
// Usage: one input beat (sensor_value_i, sensor_pressed_i) is taken when
// in_valid_i is high and in_stall_o is low. The block picks a color from the
// light rule and sends one output beat per led from led_begin up to
// led_end-1, last_o marking the final one. A beat leaves when out_valid_o
// is high and out_stall_i is low; a stalled beat holds, and the fill simply
// waits for the receiver. Rule registers must be written over the cfg channel
// (cfg_ready_o is always high) only while idle; the block does not enforce it.
// Flow: a plain color goes straight to the led beats; a blended color first
// goes through the shared multiplier and the one-bit-a-cycle restoring
// divider, each of the three channels in turn. Then one led beat per cycle
// while the receiver takes them. A disabled rule, an empty range or a bound
// past LED_TOTAL gives no beats.
// in_stall_o is high from the cycle after an accept until the last led beat
// is loaded into the output register; the next reading is taken while that
// beat still waits.
// Reset: all rule registers clear to 0 (rule disabled), no beat pending.
module sensor_to_led_color_fill #(
  parameter int unsigned LED_TOTAL = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stlcf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [stlcf_pkg::ColorW-1:0]    cfg_data_i,
  // sensor input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [stlcf_pkg::SensorW-1:0]   sensor_value_i,
  input  logic                            sensor_pressed_i,
  // led output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [stlcf_pkg::IndexW-1:0]    led_index_o,
  output logic [stlcf_pkg::ChanW-1:0]     red_o,
  output logic [stlcf_pkg::ChanW-1:0]     green_o,
  output logic [stlcf_pkg::ChanW-1:0]     blue_o,
  output logic                            last_o
);

  `include "sensor_to_led_color_fill_assert.svh"

  localparam logic [stlcf_pkg::BoundW-1:0] LedTotal = stlcf_pkg::BoundW'(LED_TOTAL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ACC,
    S_EMIT
  } state_e;

  // rule registers
  logic [stlcf_pkg::ColorW-1:0]  on_color_q, on_fade_color_q, off_color_q, off_fade_color_q;
  logic [stlcf_pkg::SensorW-1:0] threshold_q;
  logic [stlcf_pkg::FlagsW-1:0]  rule_flags_q;
  logic [stlcf_pkg::BoundW-1:0]  led_begin_q, led_end_q;

  // sequencer and datapath registers
  state_e                              state_q;
  logic [1:0]                          ch_q;
  logic [stlcf_pkg::CntW-1:0]          cnt_q;
  logic signed [stlcf_pkg::DiffW-1:0]  x_diff_q;
  logic [stlcf_pkg::SensorW-1:0]       den_q;
  logic                                span_neg_q;
  logic                                neg_q;
  logic [stlcf_pkg::MagW-1:0]          quo_q;
  logic [stlcf_pkg::SensorW-1:0]       rem_q;
  logic [stlcf_pkg::ColorW-1:0]        start_q, target_q, col_q;
  logic [stlcf_pkg::BoundW-1:0]        led_q;

  // output register
  logic                                out_valid_q;
  logic [stlcf_pkg::IndexW-1:0]        out_index_q;
  logic [stlcf_pkg::ChanW-1:0]         out_red_q, out_green_q, out_blue_q;
  logic                                out_last_q;

  assign cfg_ready_o = 1'b1;

  // config writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_color_q       <= '0;
      on_fade_color_q  <= '0;
      off_color_q      <= '0;
      off_fade_color_q <= '0;
      threshold_q      <= '0;
      rule_flags_q     <= '0;
      led_begin_q      <= '0;
      led_end_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stlcf_pkg::CFG_ON_COLOR:       on_color_q       <= cfg_data_i;
        stlcf_pkg::CFG_ON_FADE_COLOR:  on_fade_color_q  <= cfg_data_i;
        stlcf_pkg::CFG_OFF_COLOR:      off_color_q      <= cfg_data_i;
        stlcf_pkg::CFG_OFF_FADE_COLOR: off_fade_color_q <= cfg_data_i;
        stlcf_pkg::CFG_THRESHOLD:      threshold_q      <= cfg_data_i[15:0];
        stlcf_pkg::CFG_RULE_FLAGS:     rule_flags_q     <= cfg_data_i[2:0];
        stlcf_pkg::CFG_LED_BEGIN:      led_begin_q      <= cfg_data_i[6:0];
        stlcf_pkg::CFG_LED_END:        led_end_q        <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // rule selection for the incoming reading
  logic [stlcf_pkg::SensorW-1:0]      thr2, sel_lo, sel_hi;
  logic [stlcf_pkg::ColorW-1:0]       sel_a, sel_b, sel_col;
  logic                               sel_blend;
  logic signed [stlcf_pkg::DiffW-1:0] span, x_diff;
  logic [stlcf_pkg::DiffW-1:0]        span_mag;
  logic                               fill_ok;

  always_comb begin
    thr2      = {threshold_q[14:0], 1'b0};
    sel_lo    = '0;
    sel_hi    = threshold_q;
    sel_a     = off_color_q;
    sel_b     = off_fade_color_q;
    sel_col   = off_color_q;
    sel_blend = 1'b0;
    if (sensor_pressed_i) begin
      sel_lo  = threshold_q;
      sel_hi  = thr2;
      sel_a   = on_color_q;
      sel_b   = on_fade_color_q;
      sel_col = on_color_q;
      if (rule_flags_q[stlcf_pkg::FlagFadePressed]) begin
        if (sensor_value_i > thr2) begin
          sel_col = on_fade_color_q;
        end else begin
          sel_blend = 1'b1;
        end
      end
    end else if (rule_flags_q[stlcf_pkg::FlagFadeRelease]) begin
      sel_blend = 1'b1;
    end
    span     = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo});
    x_diff   = $signed({1'b0, sensor_value_i}) - $signed({1'b0, sel_lo});
    span_mag = span[stlcf_pkg::DiffW-1] ? stlcf_pkg::DiffW'(-span) : span;
    // zero span falls back to the start color
    if (sel_blend && span == '0) begin
      sel_blend = 1'b0;
      sel_col   = sel_a;
    end
    fill_ok = rule_flags_q[stlcf_pkg::FlagEnable] && (led_begin_q <= LedTotal) &&
              (led_end_q <= LedTotal) && (led_begin_q < led_end_q);
  end

  // shared multiplier: offset times channel delta
  logic [stlcf_pkg::ChanW-1:0]         a_ch, b_ch;
  logic signed [stlcf_pkg::DeltaW-1:0] delta;
  logic signed [stlcf_pkg::ProdW-1:0]  prod;
  logic [stlcf_pkg::ProdW-1:0]         prod_mag;

  always_comb begin
    a_ch     = stlcf_pkg::chan_of(start_q, ch_q);
    b_ch     = stlcf_pkg::chan_of(target_q, ch_q);
    delta    = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
    prod     = stlcf_pkg::ProdW'(x_diff_q) * stlcf_pkg::ProdW'(delta);
    prod_mag = prod[stlcf_pkg::ProdW-1] ? stlcf_pkg::ProdW'(-prod) : prod;
  end

  // restoring divider step, one quotient bit a cycle
  logic [stlcf_pkg::SensorW:0]   rem_sh, rem_sub;
  logic                          take;
  logic [stlcf_pkg::SensorW-1:0] rem_d;

  always_comb begin
    rem_sh  = {rem_q, quo_q[stlcf_pkg::MagW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    take    = (rem_sh >= {1'b0, den_q});
    rem_d   = take ? rem_sub[stlcf_pkg::SensorW-1:0] : rem_sh[stlcf_pkg::SensorW-1:0];
  end

  // signed quotient, low byte only, plus start channel
  logic [stlcf_pkg::ChanW-1:0] q8, chan_res;

  always_comb begin
    q8       = neg_q ? stlcf_pkg::ChanW'(-quo_q[7:0]) : quo_q[7:0];
    chan_res = q8 + a_ch;
  end

  logic emit_free, emit_last;
  assign emit_free = !out_valid_q || !out_stall_i;
  assign emit_last = ((led_q + stlcf_pkg::BoundW'(1)) == led_end_q);

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      cnt_q       <= '0;
    end else begin
      // a taken beat clears unless the fill loads the next one
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && fill_ok) begin
            led_q      <= led_begin_q;
            x_diff_q   <= x_diff;
            den_q      <= span_mag[stlcf_pkg::SensorW-1:0];
            span_neg_q <= span[stlcf_pkg::DiffW-1];
            start_q    <= sel_a;
            target_q   <= sel_b;
            col_q      <= sel_col;
            ch_q       <= '0;
            state_q    <= sel_blend ? S_MUL : S_EMIT;
          end
        end
        S_MUL: begin
          quo_q   <= prod_mag[stlcf_pkg::MagW-1:0];
          rem_q   <= '0;
          neg_q   <= prod[stlcf_pkg::ProdW-1] ^ span_neg_q;
          cnt_q   <= stlcf_pkg::CntW'(stlcf_pkg::DivSteps);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_d;
          quo_q <= {quo_q[stlcf_pkg::MagW-2:0], take};
          cnt_q <= cnt_q - stlcf_pkg::CntW'(1);
          if (cnt_q == stlcf_pkg::CntW'(1)) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          case (ch_q)
            2'd0:    col_q[23:16] <= chan_res;
            2'd1:    col_q[15:8]  <= chan_res;
            default: col_q[7:0]   <= chan_res;
          endcase
          if (ch_q == stlcf_pkg::ChanLast) begin
            state_q <= S_EMIT;
          end else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_EMIT: begin
          if (emit_free) begin
            out_valid_q <= 1'b1;
            out_index_q <= led_q[stlcf_pkg::IndexW-1:0];
            out_red_q   <= col_q[23:16];
            out_green_q <= col_q[15:8];
            out_blue_q  <= col_q[7:0];
            out_last_q  <= emit_last;
            led_q       <= led_q + stlcf_pkg::BoundW'(1);
            if (emit_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign led_index_o = out_index_q;
  assign red_o       = out_red_q;
  assign green_o     = out_green_q;
  assign blue_o      = out_blue_q;
  assign last_o      = out_last_q;

  // checks on the sequencer and divider
  `STLCF_ASSERT_NOW(a_rem_below_den, state_q == S_DIV, rem_q < den_q, "divider remainder not below divisor")
  `STLCF_ASSERT_NOW(a_div_count, state_q == S_DIV, cnt_q != '0, "divider step count ran out")
  `STLCF_ASSERT_NOW(a_emit_in_range, state_q == S_EMIT, led_q < led_end_q, "led counter past range end")
  `STLCF_ASSERT_NEXT(a_last_ends_fill, state_q == S_EMIT && emit_free && emit_last, state_q == S_IDLE && out_valid_q && out_last_q, "last beat did not end the fill")

endmodule
